>>> design/lpsb_pkg.sv
`timescale 1ns / 1ps
package lpsb_pkg;

    localparam int PIXELS   = 64;
    localparam int ADDR_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int COUNT_W  = 7;
    localparam int CHAN_W   = 8;
    localparam int RGB_W    = 3 * CHAN_W;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_RST  = 7'd64;
    localparam logic [CHAN_W-1:0]  GLOBAL_RST = 8'd255;
    localparam logic [CHAN_W-1:0]  LEVEL_RST  = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_BRI = 1'd1;

    typedef enum logic [1:0] {
        CMD_SET_COLOUR = 2'd0,
        CMD_SET_LEVEL  = 2'd1,
        CMD_FADE       = 2'd2,
        CMD_READ       = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FADE_RD,
        ST_FADE_WR,
        ST_LOOK,
        ST_LOAD,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              col_we;
        logic              lvl_we;
        logic [ADDR_W-1:0] wr_addr;
        logic [RGB_W-1:0]  col_wdata;
        logic [CHAN_W-1:0] lvl_wdata;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scale_stat_t;

endpackage

>>> design/lpsb_store.sv
`timescale 1ns / 1ps
module lpsb_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lpsb_pkg::store_req_t    req,
    input  logic                    clear,
    output logic [lpsb_pkg::RGB_W-1:0]  col_rdata,
    output logic [lpsb_pkg::CHAN_W-1:0] lvl_rdata
);
    import lpsb_pkg::*;

    logic [RGB_W-1:0]  col_mem_reg [PIXELS];
    logic [CHAN_W-1:0] lvl_mem_reg [PIXELS];
    logic [PIXELS-1:0] col_vld_reg;
    logic [PIXELS-1:0] lvl_vld_reg;
    logic [RGB_W-1:0]  col_q_reg;
    logic [CHAN_W-1:0] lvl_q_reg;
    logic              col_hit_reg;
    logic              lvl_hit_reg;

    always_ff @(posedge aclk) begin
        if (req.col_we) begin
            col_mem_reg[req.wr_addr] <= req.col_wdata;
        end
        if (req.lvl_we) begin
            lvl_mem_reg[req.wr_addr] <= req.lvl_wdata;
        end
        if (req.rd_en) begin
            col_q_reg <= col_mem_reg[req.rd_addr];
            lvl_q_reg <= lvl_mem_reg[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            col_vld_reg <= '0;
            lvl_vld_reg <= '0;
        end else begin
            if (req.col_we) begin
                col_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.lvl_we) begin
                lvl_vld_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_hit_reg <= 1'b0;
            lvl_hit_reg <= 1'b0;
        end else if (req.rd_en) begin
            col_hit_reg <= col_vld_reg[req.rd_addr];
            lvl_hit_reg <= lvl_vld_reg[req.rd_addr];
        end
    end

    assign col_rdata = col_hit_reg ? col_q_reg : '0;
    assign lvl_rdata = lvl_hit_reg ? lvl_q_reg : LEVEL_RST;

endmodule

>>> design/lpsb_scale.sv
`timescale 1ns / 1ps
module lpsb_scale (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lpsb_pkg::CHAN_W-1:0] glob,
    input  logic [lpsb_pkg::CHAN_W-1:0] local_lvl,
    input  logic [lpsb_pkg::RGB_W-1:0]  rgb,
    output logic [lpsb_pkg::RGB_W-1:0]  shown,
    output lpsb_pkg::scale_stat_t       stat
);
    import lpsb_pkg::*;

    localparam int BASE_W = 2 * CHAN_W + 1;
    localparam int MULB_W = CHAN_W + 1;
    localparam int PROD_W = BASE_W + MULB_W;

    logic              busy_reg;
    logic [1:0]        step_reg;
    logic [BASE_W-1:0] base_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [BASE_W-1:0] mul_a;
    logic [MULB_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [MULB_W-1:0] glob_p1;

    assign glob_p1 = {1'b0, glob} + MULB_W'(1);

    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_a = BASE_W'(local_lvl);
                mul_b = glob_p1;
            end
            2'd1: begin
                mul_a = base_reg;
                mul_b = MULB_W'(rgb[3*CHAN_W-1:2*CHAN_W]);
            end
            2'd2: begin
                mul_a = base_reg;
                mul_b = MULB_W'(rgb[2*CHAN_W-1:CHAN_W]);
            end
            default: begin
                mul_a = base_reg;
                mul_b = MULB_W'(rgb[CHAN_W-1:0]);
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= 2'd0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            case (step_reg)
                2'd0:    base_reg  <= mul_p[BASE_W-1:0];
                2'd1:    red_reg   <= mul_p[2*CHAN_W+CHAN_W-1:2*CHAN_W];
                2'd2:    green_reg <= mul_p[2*CHAN_W+CHAN_W-1:2*CHAN_W];
                default: blue_reg  <= mul_p[2*CHAN_W+CHAN_W-1:2*CHAN_W];
            endcase
        end
    end

    assign shown     = {red_reg, green_reg, blue_reg};
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (step_reg == 2'd3);

endmodule

>>> design/led_pixel_store_with_brightness_top.sv
`timescale 1ns / 1ps
// Store of 64 LED pixels, each with an RGB colour and its own brightness,
// commanded one word at a time; every command returns one word reporting the
// addressed LED, including its shown colour colour*(global+1)*level>>16.
// Single-LED writes and reads pass through the execute, look-up, load, scale
// and done states; the next word is accepted in the cycle after the result is
// loaded. A broadcast write steps through the LEDs in use and a fade reads
// then writes each of them, set by the single write port of each store
// memory. The shown colour comes from one shared multiplier used four times.
// A result held back by the output stalls the block until it is taken.
// Writing led_count clears the store at once; the configuration port is
// always ready and is to be written only while no command is in progress.
module led_pixel_store_with_brightness_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // index, red, green, blue, level, zero pad
    input  logic [lpsb_pkg::S_DATA_W-1:0]    s_tdata,
    // cmd
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // stored_red, stored_green, stored_blue, led_level,
    // shown_red, shown_green, shown_blue
    output logic [lpsb_pkg::M_DATA_W-1:0]    m_tdata,
    // ok
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpsb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lpsb_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0]  cnt_next;
    cmd_t               cmd_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic [RGB_W-1:0]   rgb_reg;
    logic [CHAN_W-1:0]  lvl_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [CHAN_W-1:0]  glob_reg;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    store_req_t         sreq;
    logic               store_clear;
    logic [RGB_W-1:0]   col_rdata;
    logic [CHAN_W-1:0]  lvl_rdata;
    logic               sc_start;
    scale_stat_t        sc_stat;
    logic [RGB_W-1:0]   shown;

    logic [COUNT_W-1:0] n_use;
    logic [COUNT_W-1:0] n_m1;
    logic [COUNT_W-1:0] idx_m1;
    logic [ADDR_W-1:0]  addr;
    logic               idx_ok;
    logic               n_nz;
    logic               ok;
    logic               out_load;
    logic [CHAN_W-1:0]  faded;
    logic               s_acc;
    logic               cfg_acc;

    assign s_acc   = s_tvalid && s_tready;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign cfg_ready   = 1'b1;
    assign store_clear = cfg_acc && (cfg_index == REG_LED_COUNT);

    assign n_use  = (int'(count_reg) > PIXELS) ? COUNT_W'(PIXELS) : count_reg;
    assign n_m1   = n_use - COUNT_W'(1);
    assign n_nz   = (n_use != '0);
    assign idx_m1 = idx_reg - COUNT_W'(1);
    assign addr   = idx_m1[ADDR_W-1:0];
    assign idx_ok = (idx_reg != '0) && (idx_reg <= n_use);
    assign faded  = (lvl_rdata >= lvl_reg) ? (lvl_rdata - lvl_reg) : '0;

    always_comb begin
        case (cmd_reg)
            CMD_SET_COLOUR, CMD_SET_LEVEL: ok = ((idx_reg == '0) && n_nz) || idx_ok;
            CMD_FADE:                      ok = n_nz;
            default:                       ok = idx_ok;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sreq           = '0;
        sreq.col_wdata = rgb_reg;
        sreq.lvl_wdata = lvl_reg;
        sc_start       = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cnt_next   = '0;
                state_next = ST_LOOK;
                if (cmd_reg == CMD_SET_COLOUR || cmd_reg == CMD_SET_LEVEL) begin
                    if (idx_reg == '0 && n_nz) begin
                        state_next = ST_WALK;
                    end else if (idx_ok) begin
                        sreq.col_we  = (cmd_reg == CMD_SET_COLOUR);
                        sreq.lvl_we  = (cmd_reg == CMD_SET_LEVEL);
                        sreq.wr_addr = addr;
                    end
                end else if (cmd_reg == CMD_FADE && n_nz) begin
                    state_next = ST_FADE_RD;
                end
            end
            ST_WALK: begin
                sreq.col_we  = (cmd_reg == CMD_SET_COLOUR);
                sreq.lvl_we  = (cmd_reg == CMD_SET_LEVEL);
                sreq.wr_addr = cnt_reg;
                cnt_next     = cnt_reg + ADDR_W'(1);
                if (cnt_reg == n_m1[ADDR_W-1:0]) begin
                    state_next = ST_LOOK;
                end
            end
            ST_FADE_RD: begin
                sreq.rd_en   = 1'b1;
                sreq.rd_addr = cnt_reg;
                state_next   = ST_FADE_WR;
            end
            ST_FADE_WR: begin
                sreq.lvl_we    = 1'b1;
                sreq.wr_addr   = cnt_reg;
                sreq.lvl_wdata = faded;
                cnt_next       = cnt_reg + ADDR_W'(1);
                state_next     = (cnt_reg == n_m1[ADDR_W-1:0]) ? ST_LOOK : ST_FADE_RD;
            end
            ST_LOOK: begin
                sreq.rd_en   = 1'b1;
                sreq.rd_addr = addr;
                state_next   = ST_LOAD;
            end
            ST_LOAD: begin
                sc_start   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (sc_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg <= cmd_t'(s_tuser);
            idx_reg <= s_tdata[6:0];
            rgb_reg <= {s_tdata[14:7], s_tdata[22:15], s_tdata[30:23]};
            lvl_reg <= s_tdata[38:31];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RST;
            glob_reg  <= GLOBAL_RST;
        end else if (cfg_acc) begin
            case (cfg_index)
                REG_LED_COUNT:  count_reg <= cfg_data[COUNT_W-1:0];
                REG_GLOBAL_BRI: glob_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= ok;
            if (idx_ok) begin
                m_tdata_reg <= {shown[CHAN_W-1:0], shown[2*CHAN_W-1:CHAN_W],
                                shown[RGB_W-1:2*CHAN_W], lvl_rdata,
                                col_rdata[CHAN_W-1:0], col_rdata[2*CHAN_W-1:CHAN_W],
                                col_rdata[RGB_W-1:2*CHAN_W]};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    lpsb_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (sreq),
        .clear     (store_clear),
        .col_rdata (col_rdata),
        .lvl_rdata (lvl_rdata)
    );

    lpsb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sc_start),
        .glob      (glob_reg),
        .local_lvl (lvl_rdata),
        .rgb       (col_rdata),
        .shown     (shown),
        .stat      (sc_stat)
    );

`ifndef SYNTHESIS
    a_acc_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start execution");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK || state_reg == ST_FADE_WR) |->
            (COUNT_W'(cnt_reg) < n_use))
        else $error("walk counter past count in use");

    a_scale_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_start |-> !sc_stat.busy)
        else $error("scale unit restarted while busy");

    a_nok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed command reports nonzero fields");
`endif

endmodule

>>> dv/led_pixel_store_with_brightness_top_tb.sv
`timescale 1ns / 1ps
module led_pixel_store_with_brightness_top_tb;
    import lpsb_pkg::*;

    typedef struct packed {
        bit       ok;
        bit [7:0] stored_r;
        bit [7:0] stored_g;
        bit [7:0] stored_b;
        bit [7:0] level;
        bit [7:0] shown_r;
        bit [7:0] shown_g;
        bit [7:0] shown_b;
    } pixel_word_t;

    typedef struct {
        cmd_t        cmd;
        bit [6:0]    idx;
        bit [7:0]    r;
        bit [7:0]    g;
        bit [7:0]    b;
        bit [7:0]    lvl;
        bit          typed;
        pixel_word_t want;
    } stim_row_t;

    localparam pixel_word_t NOT_OK = '0;
    localparam pixel_word_t OK_BLANK = '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam pixel_word_t FRESH = '{1'b1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
    localparam pixel_word_t WHITE =
        '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254};

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit [23:0]   colour_mem [PIXELS];
    bit [7:0]    level_mem [PIXELS];
    bit [6:0]    led_count_q = COUNT_RST;
    bit [7:0]    global_q = GLOBAL_RST;
    pixel_word_t pending_words [$];
    stim_row_t   directed_rows [$];
    int          errors = 0;
    int          send_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;

    led_pixel_store_with_brightness_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("led_pixel_store_with_brightness_top_tb NOT OK");
        $finish;
    end

    function automatic int active_leds();
        return (int'(led_count_q) > PIXELS) ? PIXELS : int'(led_count_q);
    endfunction

    function automatic bit [7:0] shade(bit [7:0] chan, bit [7:0] loc);
        int unsigned prod;
        prod = int'(chan) * (int'(global_q) + 1) * int'(loc);
        return prod[23:16];
    endfunction

    function automatic void clear_pixels();
        for (int i = 0; i < PIXELS; i++) begin
            colour_mem[i] = '0;
            level_mem[i] = LEVEL_RST;
        end
    endfunction

    function automatic pixel_word_t apply_command(cmd_t cmd, bit [6:0] idx,
                                                  bit [7:0] r, bit [7:0] g,
                                                  bit [7:0] b, bit [7:0] lvl);
        pixel_word_t res;
        int          n;
        bit          hit;
        bit [23:0]   c;
        res = '0;
        n = active_leds();
        hit = (idx >= 1) && (int'(idx) <= n);
        case (cmd)
            CMD_SET_COLOUR, CMD_SET_LEVEL: begin
                if (n != 0 && idx == 0) begin
                    for (int i = 0; i < n; i++) begin
                        if (cmd == CMD_SET_COLOUR)
                            colour_mem[i] = {r, g, b};
                        else
                            level_mem[i] = lvl;
                    end
                    res.ok = 1'b1;
                end else if (hit) begin
                    if (cmd == CMD_SET_COLOUR)
                        colour_mem[idx - 1] = {r, g, b};
                    else
                        level_mem[idx - 1] = lvl;
                    res.ok = 1'b1;
                end
            end
            CMD_FADE: begin
                for (int i = 0; i < n; i++)
                    level_mem[i] = (level_mem[i] >= lvl) ? level_mem[i] - lvl : 8'd0;
                res.ok = (n != 0);
            end
            default: res.ok = hit;
        endcase
        if (hit) begin
            c = colour_mem[idx - 1];
            res.stored_r = c[23:16];
            res.stored_g = c[15:8];
            res.stored_b = c[7:0];
            res.level = level_mem[idx - 1];
            res.shown_r = shade(c[23:16], res.level);
            res.shown_g = shade(c[15:8], res.level);
            res.shown_b = shade(c[7:0], res.level);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic offer_word(cmd_t cmd, bit [6:0] idx, bit [7:0] r, bit [7:0] g,
                              bit [7:0] b, bit [7:0] lvl, bit typed, pixel_word_t want);
        pixel_word_t pred;
        if ($urandom_range(99) < send_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, lvl, b, g, r, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = apply_command(cmd, idx, r, g, b, lvl);
        pending_words.push_back(typed ? want : pred);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] which, bit [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (which == REG_LED_COUNT) begin
            led_count_q = value[6:0];
            clear_pixels();
        end else begin
            global_q = value;
        end
    endtask

    task automatic configure(bit wr_count, bit [7:0] count_data, bit [7:0] bright);
        if (wr_count)
            write_reg(REG_LED_COUNT, count_data);
        write_reg(REG_GLOBAL_BRI, bright);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : collect
        pixel_word_t got;
        pixel_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok = m_tuser;
            got.stored_r = m_tdata[7:0];
            got.stored_g = m_tdata[15:8];
            got.stored_b = m_tdata[23:16];
            got.level = m_tdata[31:24];
            got.shown_r = m_tdata[39:32];
            got.shown_g = m_tdata[47:40];
            got.shown_b = m_tdata[55:48];
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word, ok", got.ok, 0);
            end else begin
                want = pending_words.pop_front();
                if (got.ok != want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.stored_r != want.stored_r)
                    report_mismatch("stored_red", got.stored_r, want.stored_r);
                if (got.stored_g != want.stored_g)
                    report_mismatch("stored_green", got.stored_g, want.stored_g);
                if (got.stored_b != want.stored_b)
                    report_mismatch("stored_blue", got.stored_b, want.stored_b);
                if (got.level != want.level)
                    report_mismatch("led_level", got.level, want.level);
                if (got.shown_r != want.shown_r)
                    report_mismatch("shown_red", got.shown_r, want.shown_r);
                if (got.shown_g != want.shown_g)
                    report_mismatch("shown_green", got.shown_g, want.shown_g);
                if (got.shown_b != want.shown_b)
                    report_mismatch("shown_blue", got.shown_b, want.shown_b);
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        bit [7:0] ph_count [9];
        bit [7:0] ph_bright [9];
        bit       ph_wr_count [9];
        int       ph_send [9];
        int       ph_stall [9];
        int       ph_words [9];
        int       n;
        int       p;
        int       q;
        cmd_t     cmd;
        bit [6:0] idx;
        bit [7:0] lvl;

        ph_count = '{8'd64, 8'd5, 8'd0, 8'd1, 8'hE4, 8'h7F, 8'd64, 8'd33, 8'd64};
        ph_bright = '{8'd255, 8'd0, 8'd200, 8'd255, 8'd128, 8'd0, 8'd77, 8'd1, 8'd255};
        ph_wr_count = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        ph_send = '{0, 53, 0, 28, 53, 0, 28, 0, 28};
        ph_stall = '{0, 0, 53, 28, 0, 53, 28, 0, 28};
        ph_words = '{150, 140, 40, 120, 150, 150, 150, 150, 120};

        clear_pixels();
        directed_rows = '{
            '{CMD_READ,       7'd1,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, FRESH},
            '{CMD_READ,       7'd0,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, NOT_OK},
            '{CMD_READ,       7'd64,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, FRESH},
            '{CMD_READ,       7'd65,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, NOT_OK},
            '{CMD_READ,       7'd127, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, NOT_OK},
            '{CMD_SET_COLOUR, 7'd1,   8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, WHITE},
            '{CMD_SET_COLOUR, 7'd64,  8'h80, 8'h01, 8'h7F, 8'h55, 1'b0, NOT_OK},
            '{CMD_SET_LEVEL,  7'd64,  8'h00, 8'h00, 8'h00, 8'h80, 1'b0, NOT_OK},
            '{CMD_SET_COLOUR, 7'd0,   8'h12, 8'h34, 8'h56, 8'h00, 1'b1, OK_BLANK},
            '{CMD_SET_COLOUR, 7'd65,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, NOT_OK},
            '{CMD_SET_LEVEL,  7'd1,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NOT_OK},
            '{CMD_SET_LEVEL,  7'd0,   8'h00, 8'h00, 8'h00, 8'hAA, 1'b1, OK_BLANK},
            '{CMD_SET_LEVEL,  7'd127, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, NOT_OK},
            '{CMD_READ,       7'd2,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NOT_OK},
            '{CMD_FADE,       7'd0,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, OK_BLANK},
            '{CMD_FADE,       7'd5,   8'h00, 8'h00, 8'h00, 8'h55, 1'b0, NOT_OK},
            '{CMD_FADE,       7'd70,  8'h00, 8'h00, 8'h00, 8'h01, 1'b1, OK_BLANK},
            '{CMD_FADE,       7'd3,   8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, NOT_OK},
            '{CMD_READ,       7'd3,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NOT_OK},
            '{CMD_SET_COLOUR, 7'd2,   8'hFF, 8'h00, 8'h80, 8'h00, 1'b0, NOT_OK},
            '{CMD_SET_LEVEL,  7'd2,   8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, NOT_OK},
            '{CMD_READ,       7'd2,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NOT_OK}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_word(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].r,
                       directed_rows[i].g, directed_rows[i].b, directed_rows[i].lvl,
                       directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 9; ph++) begin
            settle();
            configure(ph_wr_count[ph], ph_count[ph], ph_bright[ph]);
            send_pct = ph_send[ph];
            stall_pct = ph_stall[ph];
            n = active_leds();
            for (int k = 0; k < ph_words[ph]; k++) begin
                // starve the output for a while and let the input back up
                if (ph == 0 && k == 20)
                    hold_req = 300;
                p = $urandom_range(99);
                q = $urandom_range(99);
                if (p < 35)
                    cmd = CMD_READ;
                else if (p < 62)
                    cmd = CMD_SET_COLOUR;
                else if (p < 86)
                    cmd = CMD_SET_LEVEL;
                else
                    cmd = CMD_FADE;
                if (q < 6)
                    idx = 7'd0;
                else if (q < 12 || n == 0)
                    idx = 7'($urandom_range(n + 1, 127));
                else
                    idx = 7'($urandom_range(1, n));
                if (cmd == CMD_FADE && $urandom_range(99) < 80)
                    lvl = 8'($urandom_range(0, 3));
                else
                    lvl = 8'($urandom);
                offer_word(cmd, idx, 8'($urandom), 8'($urandom), 8'($urandom), lvl,
                           1'b0, NOT_OK);
            end
        end

        settle();
        if (errors == 0 && pending_words.size() == 0)
            $display("led_pixel_store_with_brightness_top_tb OK");
        else
            $display("led_pixel_store_with_brightness_top_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
design/lpsb_pkg.sv
design/lpsb_store.sv
design/lpsb_scale.sv
design/led_pixel_store_with_brightness_top.sv
dv/led_pixel_store_with_brightness_top_tb.sv
